### rtl/software_timer_table_scheduler_unit_defines.svh
// Assertion macros used by the checker file stts_checker.sv
`ifndef SOFTWARE_TIMER_TABLE_SCHEDULER_UNIT_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define STTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define STTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stts_pkg.sv
package stts_pkg;

    localparam int STTS_SLOTS  = 16;
    localparam int SLOT_ID_W   = 6;
    localparam int IVAL_W      = 48;
    localparam int TIME_W      = 63;
    localparam int WINDOW_W    = 32;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000000;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_READ_IV = 3'd1,
        OP_SET_IV  = 3'd2,
        OP_ONESHOT = 3'd3,
        OP_DELETE  = 3'd4,
        OP_TICK    = 3'd5
    } t_opcode;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_NOSUCH = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

    typedef enum logic [2:0] {
        C_NONE, C_CREATE, C_SET_IV, C_ONESHOT, C_DELETE, C_LOAD, C_RANK, C_FIRE
    } t_cell_op;

    // command broadcast to every cell
    typedef struct packed {
        t_cell_op              op;
        logic                  periodic;
        logic [IVAL_W-1:0]     interval;
        logic [TIME_W-1:0]     expiry;
        logic [TIME_W-1:0]     limit;
        logic [SLOT_ID_W:0]    rank;
    } t_cell_cmd;

    // entry travelling round the ring
    typedef struct packed {
        logic [TIME_W-1:0]    expiry;
        logic [SLOT_ID_W-1:0] id;
        logic                 due;
    } t_ring;

    // what a cell shows to the control
    typedef struct packed {
        logic              valid;
        logic [IVAL_W-1:0] interval;
        logic              hit;
    } t_cell_stat;

    // saturating time add
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [IVAL_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W+1-IVAL_W){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

### rtl/stts_ifs.sv
interface stts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [4:0]  target_id;
    logic        periodic;
    logic [47:0] interval_ns;
    logic [62:0] now_ns;
    modport source (output valid, opcode, target_id, periodic, interval_ns, now_ns,
                    input ready);
    modport sink (input valid, opcode, target_id, periodic, interval_ns, now_ns,
                  output ready);
endinterface

interface stts_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  status;
    logic [4:0]  result_id;
    logic [47:0] interval_out;
    logic        last;
    modport source (output valid, kind, status, result_id, interval_out, last,
                    input ready);
    modport sink (input valid, kind, status, result_id, interval_out, last,
                  output ready);
endinterface

### rtl/stts_cell.sv
module stts_cell
    import stts_pkg::*;
#(
    parameter int N       = STTS_SLOTS,
    parameter int CELL_ID = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_cmd  i_cmd,
    input  logic       i_sel,
    input  t_ring      i_ring,
    output t_ring      o_ring,
    output t_cell_stat o_stat
);

    localparam int RW = $clog2(N + 1);
    localparam logic [SLOT_ID_W-1:0] MY_ID = SLOT_ID_W'(CELL_ID);

    logic                 r_valid, r_periodic, r_due;
    logic [IVAL_W-1:0]    r_interval;
    logic [TIME_W-1:0]    r_expiry;
    logic [RW-1:0]        r_rank;
    t_ring                r_ring;
    logic                 w_precede, w_hit;

    // passing entry sorts ahead of this one
    assign w_precede = r_ring.due && r_due &&
                       ((r_ring.expiry < r_expiry) ||
                        ((r_ring.expiry == r_expiry) && (r_ring.id < MY_ID)));
    assign w_hit = r_due && ({{(SLOT_ID_W+1){1'b0}}, r_rank} ==
                             {{RW{1'b0}}, i_cmd.rank});

    // control state of the slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_periodic <= 1'b0;
            r_due      <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                C_CREATE: if (i_sel) begin
                    r_valid    <= 1'b1;
                    r_periodic <= i_cmd.periodic;
                end
                C_ONESHOT: if (i_sel) r_periodic <= 1'b0;
                C_DELETE:  if (i_sel) r_valid <= 1'b0;
                C_LOAD:    r_due <= r_valid && (r_expiry <= i_cmd.limit);
                C_FIRE: if (w_hit) begin
                    r_due <= 1'b0;
                    if (!r_periodic) r_valid <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload of the slot and the ring stage
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            C_CREATE: if (i_sel) begin
                r_interval <= i_cmd.interval;
                r_expiry   <= i_cmd.expiry;
            end
            C_SET_IV: if (i_sel) r_interval <= i_cmd.interval;
            C_LOAD: begin
                r_ring.expiry <= r_expiry;
                r_ring.id     <= MY_ID;
                r_ring.due    <= r_valid && (r_expiry <= i_cmd.limit);
                r_rank        <= '0;
            end
            C_RANK: begin
                if (w_precede) r_rank <= r_rank + 1'b1;
                r_ring <= i_ring;
            end
            C_FIRE: if (w_hit && r_periodic) r_expiry <= i_cmd.expiry;
            default: ;
        endcase
    end

    assign o_ring          = r_ring;
    assign o_stat.valid    = r_valid;
    assign o_stat.interval = r_interval;
    assign o_stat.hit      = w_hit;

endmodule

### rtl/software_timer_table_scheduler_unit.sv
// Non-tick request: one reply, loaded into the result register by the exec state once it is free.
// Tick: exec, load, N ring steps to rank the due timers, then one result a cycle for each of F fired
// timers while the output is not stalled, and a final reply.
// Throughput is set by the ring of N cells that ranks the due timers, one step a cycle.
// Output stalls hold the sequencer; a waiting result does not block the next transfer in.
// Reset (synchronous, active low) frees every slot, sets fire_window_ns to 1000000.
module software_timer_table_scheduler_unit
    import stts_pkg::*;
#(
    parameter int TIMER_SLOTS = STTS_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stts_req_if.sink         i_req,
    stts_res_if.source       o_res,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int N  = TIMER_SLOTS;
    localparam int RW = $clog2(N + 1);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_LOAD, S_RANK, S_FIRE} t_state;

    t_state                 r_state;
    logic [WINDOW_W-1:0]    r_window;
    logic [2:0]             r_op;
    logic [4:0]             r_tid;
    logic                   r_per;
    logic [IVAL_W-1:0]      r_iv;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      r_limit;
    logic [RW-1:0]          r_cnt;
    logic                   r_ov, r_kind, r_last;
    logic [1:0]             r_status;
    logic [4:0]             r_id;
    logic [IVAL_W-1:0]      r_ival;

    t_cell_cmd              w_cmd;
    t_ring                  w_ring [N];
    t_cell_stat             w_stat [N];
    logic [N-1:0]           w_sel_id, w_sel, w_valid, w_hit;
    logic                   w_found, w_full, w_any_hit, w_free, w_push;
    logic [SLOT_ID_W-1:0]   w_free_id, w_hit_id;
    logic [IVAL_W-1:0]      w_rd_iv, w_hit_iv, w_addend;
    logic [TIME_W-1:0]      w_sum;
    logic [1:0]             w_rep_status;
    logic [4:0]             w_rep_id;
    logic [IVAL_W-1:0]      w_rep_ival;
    t_opcode                w_op;

    assign w_op   = t_opcode'(r_op);
    assign w_free = !r_ov || o_res.ready;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : r_window;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_window <= pwdata;
        end
    end

    // decode of id, free slot and fired slot
    always_comb begin
        w_free_id = '0;
        w_rd_iv   = '0;
        w_hit_id  = '0;
        w_hit_iv  = '0;
        for (int i = 0; i < N; i++) begin
            w_valid[i]  = w_stat[i].valid;
            w_hit[i]    = w_stat[i].hit;
            w_sel_id[i] = ({1'b0, r_tid} == SLOT_ID_W'(i + 1));
            if (w_sel_id[i] && w_valid[i]) w_rd_iv = w_rd_iv | w_stat[i].interval;
            if (w_hit[i]) begin
                w_hit_id = w_hit_id | SLOT_ID_W'(i + 1);
                w_hit_iv = w_hit_iv | w_stat[i].interval;
            end
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (!w_valid[i]) w_free_id = SLOT_ID_W'(i + 1);
        end
    end

    assign w_found   = |(w_sel_id & w_valid);
    assign w_full    = &w_valid;
    assign w_any_hit = |w_hit;

    // shared saturating adder
    always_comb begin
        if (r_state == S_FIRE)       w_addend = w_hit_iv;
        else if (w_op == OP_TICK)    w_addend = {{(IVAL_W-WINDOW_W){1'b0}}, r_window};
        else                         w_addend = r_iv;
    end
    assign w_sum = sat_add(r_now, w_addend);

    // reply to a request other than tick
    always_comb begin
        w_rep_status = ST_OK;
        w_rep_id     = '0;
        w_rep_ival   = '0;
        priority case (w_op)
            OP_CREATE: begin
                if (r_iv == '0)  w_rep_status = ST_BAD;
                else if (w_full) w_rep_status = ST_FULL;
                else             w_rep_id = 5'(w_free_id);
            end
            OP_READ_IV, OP_SET_IV, OP_ONESHOT, OP_DELETE: begin
                if (!w_found)                w_rep_status = ST_NOSUCH;
                else if (w_op == OP_READ_IV) w_rep_ival = w_rd_iv;
            end
            default: w_rep_status = ST_BAD;
        endcase
    end

    // load a new result into the output register
    assign w_push = w_free && (((r_state == S_EXEC) && (w_op != OP_TICK)) ||
                               (r_state == S_FIRE));

    // cell command
    always_comb begin
        w_cmd.op       = C_NONE;
        w_cmd.periodic = r_per;
        w_cmd.interval = r_iv;
        w_cmd.expiry   = w_sum;
        w_cmd.limit    = r_limit;
        w_cmd.rank     = {{(SLOT_ID_W+1-RW){1'b0}}, r_cnt};
        w_sel          = w_sel_id & w_valid;
        unique case (r_state)
            S_EXEC: if (w_free) begin
                priority case (w_op)
                    OP_CREATE: begin
                        for (int i = 0; i < N; i++) begin
                            w_sel[i] = (w_free_id == SLOT_ID_W'(i + 1));
                        end
                        if (r_iv != '0 && !w_full) w_cmd.op = C_CREATE;
                    end
                    OP_SET_IV:  w_cmd.op = C_SET_IV;
                    OP_ONESHOT: w_cmd.op = C_ONESHOT;
                    OP_DELETE:  w_cmd.op = C_DELETE;
                    default: ;
                endcase
            end
            S_LOAD: w_cmd.op = C_LOAD;
            S_RANK: w_cmd.op = C_RANK;
            S_FIRE: if (w_free) w_cmd.op = C_FIRE;
            default: ;
        endcase
    end

    // ring of slot cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        stts_cell #(.N(N), .CELL_ID(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_sel   (w_sel[g]),
            .i_ring  (w_ring[(g + N - 1) % N]),
            .o_ring  (w_ring[g]),
            .o_stat  (w_stat[g])
        );
    end

    assign i_req.ready = (r_state == S_IDLE);

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (w_push)           r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_req.valid) begin
                    r_op    <= i_req.opcode;
                    r_tid   <= i_req.target_id;
                    r_per   <= i_req.periodic;
                    r_iv    <= i_req.interval_ns;
                    r_now   <= i_req.now_ns;
                    r_state <= S_EXEC;
                end
                S_EXEC: if (w_op == OP_TICK) begin
                    r_limit <= w_sum;
                    r_state <= S_LOAD;
                end else if (w_free) begin
                    r_kind   <= KIND_REPLY;
                    r_last   <= 1'b1;
                    r_id     <= w_rep_id;
                    r_ival   <= w_rep_ival;
                    r_status <= w_rep_status;
                    r_state  <= S_IDLE;
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_RANK;
                end
                S_RANK: begin
                    if (r_cnt == RW'(N - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_FIRE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIRE: if (w_free) begin
                    r_status <= ST_OK;
                    r_ival   <= '0;
                    if (w_any_hit) begin
                        r_kind <= KIND_FIRE;
                        r_last <= 1'b0;
                        r_id   <= 5'(w_hit_id);
                        r_cnt  <= r_cnt + 1'b1;
                    end else begin
                        r_kind  <= KIND_REPLY;
                        r_last  <= 1'b1;
                        r_id    <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.kind         = r_kind;
    assign o_res.status       = r_status;
    assign o_res.result_id    = r_id;
    assign o_res.interval_out = r_ival;
    assign o_res.last         = r_last;

endmodule

### rtl/stts_checker.sv
`include "software_timer_table_scheduler_unit_defines.svh"

module stts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_res_kind,
    input logic        i_res_last,
    input logic [1:0]  i_res_status,
    input logic [4:0]  i_res_id,
    input logic        i_pready
);

    // a stalled result holds
    `STTS_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_id) && $stable(i_res_last), "stalled result changed")
    // fired timer results are never final and carry an id
    `STTS_ASSERT_NOW(a_fire_form, i_clk, i_rst_n, i_res_valid && i_res_kind, !i_res_last && i_res_status == 2'd0 && i_res_id != 5'd0, "bad fire result")
    // every reply closes its item
    `STTS_ASSERT_NOW(a_reply_last, i_clk, i_rst_n, i_res_valid && !i_res_kind, i_res_last, "reply not last")
    // config port never waits
    `STTS_ASSERT_NOW(a_pready, i_clk, i_rst_n, 1'b1, i_pready, "pready low")

endmodule

bind software_timer_table_scheduler_unit stts_checker u_stts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_kind   (o_res.kind),
    .i_res_last   (o_res.last),
    .i_res_status (o_res.status),
    .i_res_id     (o_res.result_id),
    .i_pready     (pready)
);

### tb/software_timer_table_scheduler_unit_checker.sv
// Watch both channels and the register port, predict every result and compare
module software_timer_table_scheduler_unit_checker
    import stts_pkg::*;
#(
    parameter logic [2:0] WINDOW_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stts_req_if         req,
    stts_res_if         res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic              kind;
        logic [1:0]        status;
        logic [4:0]        id;
        logic [IVAL_W-1:0] ival;
        logic              last;
    } t_timer_result;

    // shadow copy of the timer bank
    bit                  slot_live  [STTS_SLOTS];
    bit                  slot_rearm [STTS_SLOTS];
    logic [IVAL_W-1:0]   slot_iv    [STTS_SLOTS];
    logic [TIME_W-1:0]   slot_exp   [STTS_SLOTS];
    logic [WINDOW_W-1:0] window;

    t_timer_result awaited_results[$];
    int            mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = awaited_results.size();

    function automatic logic [TIME_W-1:0] clamp_time(input logic [TIME_W-1:0] a,
                                                     input logic [63:0] b);
        logic [64:0] s;
        s = {2'b0, a} + {1'b0, b};
        return (s > {2'b0, TIME_MAX}) ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic t_timer_result reply(input logic [1:0] st, input logic [4:0] id,
                                            input logic [IVAL_W-1:0] iv);
        t_timer_result r;
        r.kind   = KIND_REPLY;
        r.status = st;
        r.id     = id;
        r.ival   = iv;
        r.last   = 1'b1;
        return r;
    endfunction

    // work out the results of one request and update the shadow bank
    task automatic predict_request(input logic [2:0] op, input logic [4:0] id,
                                   input logic per, input logic [IVAL_W-1:0] iv,
                                   input logic [TIME_W-1:0] now);
        int            slot;
        int            best;
        bit            due [STTS_SLOTS];
        logic [TIME_W-1:0] limit;
        t_timer_result fire;
        slot = -1;
        if (id != 0 && id <= STTS_SLOTS && slot_live[id-1])
            slot = id - 1;
        case (op)
            OP_CREATE: begin
                best = -1;
                for (int i = STTS_SLOTS - 1; i >= 0; i--)
                    if (!slot_live[i]) best = i;
                if (iv == 0)
                    awaited_results.push_back(reply(ST_BAD, 5'd0, '0));
                else if (best < 0)
                    awaited_results.push_back(reply(ST_FULL, 5'd0, '0));
                else begin
                    slot_live[best]  = 1'b1;
                    slot_rearm[best] = per;
                    slot_iv[best]    = iv;
                    slot_exp[best]   = clamp_time(now, {16'd0, iv});
                    awaited_results.push_back(reply(ST_OK, 5'(best + 1), '0));
                end
            end
            OP_READ_IV, OP_SET_IV, OP_ONESHOT, OP_DELETE: begin
                if (slot < 0)
                    awaited_results.push_back(reply(ST_NOSUCH, 5'd0, '0));
                else if (op == OP_READ_IV)
                    awaited_results.push_back(reply(ST_OK, 5'd0, slot_iv[slot]));
                else begin
                    if (op == OP_SET_IV) slot_iv[slot] = iv;
                    else if (op == OP_ONESHOT) slot_rearm[slot] = 1'b0;
                    else slot_live[slot] = 1'b0;
                    awaited_results.push_back(reply(ST_OK, 5'd0, '0));
                end
            end
            OP_TICK: begin
                limit = clamp_time(now, {32'd0, window});
                for (int i = 0; i < STTS_SLOTS; i++)
                    due[i] = slot_live[i] && slot_exp[i] <= limit;
                // fire earliest first, lower slot on a tie
                for (int n = 0; n < STTS_SLOTS; n++) begin
                    best = -1;
                    for (int i = 0; i < STTS_SLOTS; i++)
                        if (due[i] && (best < 0 || slot_exp[i] < slot_exp[best]))
                            best = i;
                    if (best >= 0) begin
                        due[best]   = 1'b0;
                        fire.kind   = KIND_FIRE;
                        fire.status = ST_OK;
                        fire.id     = 5'(best + 1);
                        fire.ival   = '0;
                        fire.last   = 1'b0;
                        awaited_results.push_back(fire);
                        if (slot_rearm[best])
                            slot_exp[best] = clamp_time(now, {16'd0, slot_iv[best]});
                        else
                            slot_live[best] = 1'b0;
                    end
                end
                awaited_results.push_back(reply(ST_OK, 5'd0, '0));
            end
            default: awaited_results.push_back(reply(ST_BAD, 5'd0, '0));
        endcase
    endtask

    task automatic report(input string what, input t_timer_result exp_r,
                          input t_timer_result got);
        if (mismatches < 10)
            $display({"mismatch (%s): expected kind %0d status %0d id %0d ival %0h",
                      " last %0d, got kind %0d status %0d id %0d ival %0h last %0d"},
                     what, exp_r.kind, exp_r.status, exp_r.id, exp_r.ival, exp_r.last,
                     got.kind, got.status, got.id, got.ival, got.last);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < STTS_SLOTS; i++) begin
                slot_live[i]  = 1'b0;
                slot_rearm[i] = 1'b0;
            end
            window = WINDOW_RESET;
            awaited_results.delete();
            mismatches = 0;
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR)
                window = pwdata;
            // compare a result transfer with the oldest expectation
            if (res.valid && res.ready) begin
                got = '{res.kind, res.status, res.result_id, res.interval_out, res.last};
                if (awaited_results.size() == 0) begin
                    exp_r = '0;
                    report("unexpected", exp_r, got);
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (got != exp_r) report("field", exp_r, got);
                end
            end
            // predict a request transfer
            if (req.valid && req.ready)
                predict_request(req.opcode, req.target_id, req.periodic, req.interval_ns,
                                req.now_ns);
        end
    end

endmodule

### tb/software_timer_table_scheduler_unit_test.sv
module software_timer_table_scheduler_unit_test;
    import stts_pkg::*;

    localparam logic [2:0] WINDOW_ADDR = 3'd0;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SETTLE      = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          calm;
    int          stall_left = 0;
    logic [TIME_W-1:0] clock_ns;

    stts_req_if req_bus ();
    stts_res_if res_bus ();

    software_timer_table_scheduler_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    software_timer_table_scheduler_unit_checker #(.WINDOW_ADDR(WINDOW_ADDR)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_bus),
        .res          (res_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // abandon a hung run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= gap_len();
        end
        res_bus.ready <= (stall_left == 0);
    end

    // offer one request and hold it until transfer
    task automatic send(input logic [2:0] op, input logic [4:0] id, input logic per,
                        input logic [IVAL_W-1:0] iv, input logic [TIME_W-1:0] now);
        int g;
        req_bus.valid       <= 1'b1;
        req_bus.opcode      <= op;
        req_bus.target_id   <= id;
        req_bus.periodic    <= per;
        req_bus.interval_ns <= iv;
        req_bus.now_ns      <= now;
        do @(posedge i_clk); while (!req_bus.ready);
        @(negedge i_clk);
        g = gap_len();
        if (g > 0) begin
            req_bus.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    // drain every result, let the ranking ring settle, then write the window
    task automatic set_window(input logic [31:0] value);
        req_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [IVAL_W-1:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 15) return {$urandom, $urandom};
        return $urandom_range(1, 3000000);
    endfunction

    // one random request; mostly a plausible sequence on a forward-running clock
    task automatic random_request();
        int          r;
        logic [63:0] wide;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) begin
            wide = {$urandom, $urandom};
            clock_ns = wide[TIME_W-1:0];
        end else begin
            clock_ns = clock_ns + $urandom_range(0, 2000000);
        end
        if (r < 35)
            send(OP_CREATE, 5'($urandom), 1'($urandom), pick_interval(), clock_ns);
        else if (r < 62)
            send(OP_TICK, 5'($urandom), 1'($urandom), 48'({$urandom, $urandom}), clock_ns);
        else if (r < 70)
            send(OP_READ_IV, 5'($urandom_range(0, 18)), 1'($urandom), '0, clock_ns);
        else if (r < 78)
            send(OP_SET_IV, 5'($urandom_range(0, 18)), 1'($urandom), pick_interval(),
                 clock_ns);
        else if (r < 85)
            send(OP_ONESHOT, 5'($urandom_range(0, 18)), 1'($urandom), '0, clock_ns);
        else if (r < 93)
            send(OP_DELETE, 5'($urandom_range(0, 18)), 1'($urandom), '0, clock_ns);
        else if (r < 96)
            send(3'($urandom_range(6, 7)), 5'($urandom), 1'($urandom), '0, clock_ns);
        else
            send(3'($urandom_range(1, 4)), 5'($urandom_range(17, 31)), 1'($urandom),
                 '0, clock_ns);
    endtask

    initial begin
        logic [31:0] windows [4];
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_bus.valid  = 1'b0;
        req_bus.opcode = '0;
        req_bus.target_id   = '0;
        req_bus.periodic    = 1'b0;
        req_bus.interval_ns = '0;
        req_bus.now_ns      = '0;
        calm           = 1'b0;
        clock_ns       = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: bad parameters, bad ids, every operation, overflow
        send(OP_CREATE, 5'd0, 1'b0, '0, 63'd100);
        send(OP_CREATE, 5'd0, 1'b1, 48'd500, 63'd100);
        send(OP_CREATE, 5'd31, 1'b0, 48'd500, 63'd100);
        send(OP_CREATE, 5'd0, 1'b1, {IVAL_W{1'b1}}, {TIME_W{1'b1}} - 63'd10);
        send(OP_READ_IV, 5'd0, 1'b0, '0, '0);
        send(OP_READ_IV, 5'd31, 1'b0, '0, '0);
        send(OP_READ_IV, 5'd16, 1'b0, '0, '0);
        send(OP_READ_IV, 5'd3, 1'b0, '0, '0);
        send(OP_SET_IV, 5'd1, 1'b0, '0, '0);
        send(OP_READ_IV, 5'd1, 1'b0, '0, '0);
        send(OP_TICK, 5'd0, 1'b0, '0, 63'd0);
        send(OP_TICK, 5'd0, 1'b0, '0, 63'd0);
        send(OP_ONESHOT, 5'd1, 1'b0, '0, '0);
        send(OP_TICK, 5'd0, 1'b0, '0, 63'd10);
        send(3'd6, 5'd2, 1'b1, 48'd1, 63'd1);
        send(3'd7, 5'd2, 1'b1, 48'd1, 63'd1);
        send(OP_DELETE, 5'd1, 1'b0, '0, '0);
        send(OP_DELETE, 5'd2, 1'b0, '0, '0);
        send(OP_DELETE, 5'd2, 1'b0, '0, '0);
        send(OP_TICK, 5'd0, 1'b0, '0, {TIME_W{1'b1}});
        send(OP_DELETE, 5'd3, 1'b0, '0, '0);

        // random phases under several fire windows
        windows[0] = WINDOW_RESET;
        windows[1] = 32'd0;
        windows[2] = 32'hFFFF_FFFF;
        windows[3] = $urandom;
        for (int p = 0; p < 4; p++) begin
            set_window(windows[p]);
            calm = (p == 1);
            // fill the table past full once
            if (p == 2)
                for (int k = 0; k < 17; k++)
                    send(OP_CREATE, '0, 1'($urandom), 48'($urandom_range(1, 4000000)),
                         clock_ns);
            for (int k = 0; k < 18; k++) random_request();
        end

        req_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
